/* design/rhwp_pkg.sv */
`timescale 1ns / 1ps

package rhwp_pkg;

    // Widths of the channel fields
    localparam int WORD_W      = 32;
    localparam int BYTES_W     = 3;
    localparam int TAG_W       = 5;
    localparam int STATUS_W    = 3;

    // Configuration register widths and reset values
    localparam int AUTH_LIM_W  = 9;
    localparam int PAY_LIM_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [AUTH_LIM_W-1:0] AUTH_LIM_RESET = 9'd400;
    localparam logic [PAY_LIM_W-1:0]  PAY_LIM_RESET  = 16'd4096;

    // Protocol ceiling on an opaque auth body
    localparam logic [AUTH_LIM_W-1:0] AUTH_BODY_CAP = 9'd400;

    // Auth body word counter: ceil(400 / 4) fits in seven bits
    localparam int AUTH_WORDS_W = 7;

    // Default sizes handed down from the top level
    localparam int PAYLOAD_COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF         = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_AUTH_BODY = 1'd0,
        REG_MAX_PAYLOAD   = 1'd1
    } cfg_reg_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_TRUNCATED    = 3'd1,
        ST_BAD_TYPE     = 3'd2,
        ST_BAD_VERSION  = 3'd3,
        ST_AUTH_LONG    = 3'd4,
        ST_PAYLOAD_LONG = 3'd5
    } status_e;

    typedef enum logic [TAG_W-1:0] {
        TAG_XID         = 5'd0,
        TAG_MSG_TYPE    = 5'd1,
        TAG_RPCVERS     = 5'd2,
        TAG_PROG        = 5'd3,
        TAG_VERS        = 5'd4,
        TAG_PROC        = 5'd5,
        TAG_CRED_FLAVOR = 5'd6,
        TAG_CRED_LEN    = 5'd7,
        TAG_CRED_BODY   = 5'd8,
        TAG_VERF_FLAVOR = 5'd9,
        TAG_VERF_LEN    = 5'd10,
        TAG_VERF_BODY   = 5'd11,
        TAG_REPLY_STAT  = 5'd12,
        TAG_ACCEPT_STAT = 5'd13,
        TAG_REJECT_STAT = 5'd14,
        TAG_MISMATCH_LO = 5'd15,
        TAG_MISMATCH_HI = 5'd16,
        TAG_AUTH_STAT   = 5'd17,
        TAG_PAYLOAD     = 5'd18,
        TAG_DROPPED     = 5'd19
    } tag_e;

    // Parse position of the header walker
    typedef enum logic [4:0] {
        P_XID, P_TYPE, P_RPCVERS, P_PROG, P_VERS, P_PROC,
        P_CFL, P_CLEN, P_CBODY, P_VFL, P_VLEN, P_VBODY,
        P_RFL, P_RLEN, P_RBODY,
        P_RSTAT, P_ASTAT, P_JSTAT, P_MLO, P_MHI, P_ASTATUS,
        P_PAYLOAD, P_DROP
    } pos_e;

    // Classified request handed from the front to the back
    typedef struct packed {
        tag_e                 tag;
        logic [WORD_W-1:0]    value;
        logic [BYTES_W-1:0]   bytes;
        logic                 last;
        status_e              status;
    } item_t;

    // Field tag of a parse position
    function automatic tag_e tag_of(input pos_e pos);
        tag_e t;
        unique case (pos)
            P_XID:     t = TAG_XID;
            P_TYPE:    t = TAG_MSG_TYPE;
            P_RPCVERS: t = TAG_RPCVERS;
            P_PROG:    t = TAG_PROG;
            P_VERS:    t = TAG_VERS;
            P_PROC:    t = TAG_PROC;
            P_CFL:     t = TAG_CRED_FLAVOR;
            P_CLEN:    t = TAG_CRED_LEN;
            P_CBODY:   t = TAG_CRED_BODY;
            P_VFL, P_RFL:     t = TAG_VERF_FLAVOR;
            P_VLEN, P_RLEN:   t = TAG_VERF_LEN;
            P_VBODY, P_RBODY: t = TAG_VERF_BODY;
            P_RSTAT:   t = TAG_REPLY_STAT;
            P_ASTAT:   t = TAG_ACCEPT_STAT;
            P_JSTAT:   t = TAG_REJECT_STAT;
            P_MLO:     t = TAG_MISMATCH_LO;
            P_MHI:     t = TAG_MISMATCH_HI;
            P_ASTATUS: t = TAG_AUTH_STAT;
            P_PAYLOAD: t = TAG_PAYLOAD;
            default:   t = TAG_DROPPED;
        endcase
        return t;
    endfunction

    // Position that follows an auth length or body
    function automatic pos_e after_auth(input pos_e pos);
        pos_e p;
        unique case (pos)
            P_CLEN, P_CBODY: p = P_VFL;
            P_VLEN, P_VBODY: p = P_PAYLOAD;
            default:         p = P_ASTAT;
        endcase
        return p;
    endfunction

endpackage

/* design/rhwp_word_if.sv */
`timescale 1ns / 1ps

interface rhwp_word_if import rhwp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  word;
    logic [BYTES_W-1:0] valid_bytes;
    logic               end_of_datagram;

    modport source (output valid, word, valid_bytes, end_of_datagram, input ready);
    modport sink   (input valid, word, valid_bytes, end_of_datagram, output ready);
endinterface

/* design/rhwp_field_if.sv */
`timescale 1ns / 1ps

interface rhwp_field_if import rhwp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TAG_W-1:0]    field_tag;
    logic [WORD_W-1:0]   field_value;
    logic [BYTES_W-1:0]  value_bytes;
    logic                is_last;
    logic [STATUS_W-1:0] status;

    modport source (output valid, field_tag, field_value, value_bytes, is_last, status,
                    input ready);
    modport sink   (input valid, field_tag, field_value, value_bytes, is_last, status,
                    output ready);
endinterface

/* design/rhwp_front.sv */
`timescale 1ns / 1ps

module rhwp_front import rhwp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rhwp_word_if.sink             words,
    input  logic [AUTH_LIM_W-1:0] max_auth_body_bytes,
    input  logic                  q_ready,
    output logic                  q_push,
    output item_t                 q_item
);

    pos_e                    pos_reg, pos_next;
    status_e                 err_reg, err_next;
    logic [AUTH_WORDS_W-1:0] awl_reg, awl_next;

    pos_e                    step_pos;
    status_e                 step_err;
    logic [AUTH_WORDS_W-1:0] step_awl;
    logic [AUTH_LIM_W-1:0]   auth_lim;
    logic [AUTH_LIM_W:0]     len_round;
    logic [AUTH_WORDS_W-1:0] len_words;
    logic [AUTH_WORDS_W-1:0] body_left;

    // Accept whenever the queue has room
    assign words.ready = q_ready;
    assign q_push      = words.valid && q_ready;

    // Clamp the auth limit and round a body length up to whole words
    assign auth_lim  = (max_auth_body_bytes > AUTH_BODY_CAP) ? AUTH_BODY_CAP
                                                              : max_auth_body_bytes;
    assign len_round = {1'b0, words.word[AUTH_LIM_W-1:0]} + (AUTH_LIM_W+1)'(3);
    assign len_words = len_round[AUTH_LIM_W-1:2];
    assign body_left = (awl_reg != '0) ? awl_reg - AUTH_WORDS_W'(1) : awl_reg;

    // Classify the word and step the header walker
    always_comb
    begin
        step_pos = pos_reg;
        step_err = ST_OK;
        step_awl = awl_reg;

        q_item.tag    = tag_of(pos_reg);
        q_item.value  = words.word;
        q_item.bytes  = words.valid_bytes;
        q_item.last   = words.end_of_datagram;
        q_item.status = ST_OK;

        if (err_reg != ST_OK || pos_reg == P_DROP)
        begin
            q_item.tag    = TAG_DROPPED;
            q_item.status = err_reg;
        end
        else if (pos_reg == P_PAYLOAD)
        begin
            // payload limits are checked downstream
            q_item.status = ST_OK;
        end
        else
        begin
            if (words.valid_bytes != BYTES_W'(4))
            begin
                step_err = ST_TRUNCATED;
            end
            else
            begin
                unique case (pos_reg)
                    P_XID:     step_pos = P_TYPE;
                    P_TYPE:
                    begin
                        if (words.word == '0)
                            step_pos = P_RPCVERS;
                        else if (words.word == WORD_W'(1))
                            step_pos = P_RSTAT;
                        else
                            step_err = ST_BAD_TYPE;
                    end
                    P_RPCVERS:
                    begin
                        if (words.word != WORD_W'(2))
                            step_err = ST_BAD_VERSION;
                        else
                            step_pos = P_PROG;
                    end
                    P_PROG:    step_pos = P_VERS;
                    P_VERS:    step_pos = P_PROC;
                    P_PROC:    step_pos = P_CFL;
                    P_CFL:     step_pos = P_CLEN;
                    P_VFL:     step_pos = P_VLEN;
                    P_RFL:     step_pos = P_RLEN;
                    P_CLEN, P_VLEN, P_RLEN:
                    begin
                        if (words.word > {{(WORD_W-AUTH_LIM_W){1'b0}}, auth_lim})
                        begin
                            step_err = ST_AUTH_LONG;
                        end
                        else
                        begin
                            step_awl = len_words;
                            if (len_words == '0)
                                step_pos = after_auth(pos_reg);
                            else if (pos_reg == P_CLEN)
                                step_pos = P_CBODY;
                            else if (pos_reg == P_VLEN)
                                step_pos = P_VBODY;
                            else
                                step_pos = P_RBODY;
                        end
                    end
                    P_CBODY, P_VBODY, P_RBODY:
                    begin
                        step_awl = body_left;
                        step_pos = (body_left != '0) ? pos_reg : after_auth(pos_reg);
                    end
                    P_RSTAT:   step_pos = (words.word == '0) ? P_RFL : P_JSTAT;
                    P_ASTAT:   step_pos = (words.word == WORD_W'(2)) ? P_MLO : P_PAYLOAD;
                    P_JSTAT:   step_pos = (words.word == '0) ? P_MLO : P_ASTATUS;
                    P_MLO:     step_pos = P_MHI;
                    P_MHI:     step_pos = P_PAYLOAD;
                    P_ASTATUS: step_pos = P_PAYLOAD;
                    default:   step_pos = P_DROP;
                endcase
                // header cut short by the end of the datagram
                if (step_err == ST_OK && words.end_of_datagram && step_pos != P_PAYLOAD)
                    step_err = ST_TRUNCATED;
            end
            q_item.status = step_err;
            if (step_err != ST_OK)
                step_pos = P_DROP;
        end
    end

    // Advance on each request, start over after the last word
    always_comb
    begin
        pos_next = pos_reg;
        err_next = err_reg;
        awl_next = awl_reg;
        if (q_push)
        begin
            if (words.end_of_datagram)
            begin
                pos_next = P_XID;
                err_next = ST_OK;
                awl_next = '0;
            end
            else if (err_reg == ST_OK && pos_reg != P_DROP && pos_reg != P_PAYLOAD)
            begin
                pos_next = step_pos;
                awl_next = step_awl;
                if (step_err != ST_OK)
                    err_next = step_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= P_XID;
            err_reg <= ST_OK;
            awl_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
            awl_reg <= awl_next;
        end
    end

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> pos_reg == P_DROP)
        else $error("held error without drop position");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && words.end_of_datagram |=> pos_reg == P_XID && err_reg == ST_OK)
        else $error("parse did not restart after last word");

endmodule

/* design/rhwp_queue.sv */
`timescale 1ns / 1ps

module rhwp_queue import rhwp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  in_ready,
    input  logic  pop,
    output logic  out_valid,
    output item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign head_item = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_W'(DEPTH) || pop)
        else $error("push into full queue");

endmodule

/* design/rhwp_back.sv */
`timescale 1ns / 1ps

module rhwp_back import rhwp_pkg::*;
#(
    parameter int PAYLOAD_COUNT_WIDTH = PAYLOAD_COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    input  logic [PAY_LIM_W-1:0] max_payload_bytes,
    rhwp_field_if.source         fields
);

    localparam int CW = PAYLOAD_COUNT_WIDTH;
    localparam int TW = (CW + 1 > PAY_LIM_W + 1) ? CW + 1 : PAY_LIM_W + 1;

    logic [CW-1:0]      pay_count_reg, pay_count_next;
    logic               pay_drop_reg, pay_drop_next;
    logic               out_valid_reg;
    item_t              out_item_reg, out_item_next;

    logic [BYTES_W-1:0] add_bytes;
    logic [CW:0]        total;
    logic               over_limit;

    // Take a request when the output register is free or draining
    assign q_pop = q_valid && (!out_valid_reg || fields.ready);

    // Running payload total against the limit
    assign add_bytes  = (q_item.bytes > BYTES_W'(4)) ? BYTES_W'(4) : q_item.bytes;
    assign total      = {1'b0, pay_count_reg} + (CW+1)'(add_bytes);
    assign over_limit = TW'(total) > TW'(max_payload_bytes);

    always_comb
    begin
        pay_count_next = pay_count_reg;
        pay_drop_next  = pay_drop_reg;
        out_item_next  = q_item;
        if (q_item.tag == TAG_PAYLOAD)
        begin
            if (pay_drop_reg)
            begin
                out_item_next.tag    = TAG_DROPPED;
                out_item_next.status = ST_PAYLOAD_LONG;
            end
            else if (over_limit)
            begin
                out_item_next.status = ST_PAYLOAD_LONG;
                pay_drop_next        = 1'b1;
            end
            else
            begin
                // saturate at the counter width
                pay_count_next = total[CW] ? {CW{1'b1}} : total[CW-1:0];
            end
        end
        if (q_item.last)
        begin
            pay_count_next = '0;
            pay_drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_count_reg <= '0;
            pay_drop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pay_count_reg <= pay_count_next;
                pay_drop_reg  <= pay_drop_next;
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (fields.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_item_reg <= out_item_next;
    end

    assign fields.valid       = out_valid_reg;
    assign fields.field_tag   = out_item_reg.tag;
    assign fields.field_value = out_item_reg.value;
    assign fields.value_bytes = out_item_reg.bytes;
    assign fields.is_last     = out_item_reg.last;
    assign fields.status      = out_item_reg.status;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_item.last |=> pay_count_reg == '0 && !pay_drop_reg)
        else $error("payload state kept past last word");

endmodule

/* design/rpc_header_word_parser_top.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload
// words    in   valid / ready    word[31:0], valid_bytes[2:0], end_of_datagram
// fields   out  valid / ready    field_tag[4:0], field_value[31:0], value_bytes[2:0],
//                                is_last, status[2:0]
// cfg      in   cfg_we           cfg_index[0], cfg_data[15:0]
//
// One word per cycle sustained while fields is ready; an accepted word passes through the
// queue entry and then the output register before it is on fields.
// The header walker in the front decides each word combinationally.
// Reset is asynchronous, active low, and returns the parse to the xid word.
// A stalled output fills the queue; words stops accepting only once the queue is full.

module rpc_header_word_parser_top import rhwp_pkg::*;
#(
    parameter int PAYLOAD_COUNT_WIDTH = PAYLOAD_COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH         = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    rhwp_word_if.sink              words,
    rhwp_field_if.source           fields,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [AUTH_LIM_W-1:0] max_auth_reg;
    logic [PAY_LIM_W-1:0]  max_pay_reg;

    logic  q_push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    item_t push_item;
    item_t head_item;

    // Hold the limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_auth_reg <= AUTH_LIM_RESET;
            max_pay_reg  <= PAY_LIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_MAX_AUTH_BODY: max_auth_reg <= cfg_data[AUTH_LIM_W-1:0];
                REG_MAX_PAYLOAD:   max_pay_reg  <= cfg_data[PAY_LIM_W-1:0];
                default:           max_pay_reg  <= max_pay_reg;
            endcase
        end
    end

    rhwp_front u_front
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .words               (words),
        .max_auth_body_bytes (max_auth_reg),
        .q_ready             (q_ready),
        .q_push              (q_push),
        .q_item              (push_item)
    );

    rhwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .in_ready  (q_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .head_item (head_item)
    );

    rhwp_back #(
        .PAYLOAD_COUNT_WIDTH (PAYLOAD_COUNT_WIDTH)
    ) u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_item            (head_item),
        .q_pop             (q_pop),
        .max_payload_bytes (max_pay_reg),
        .fields            (fields)
    );

endmodule
